// ===== rtl/core/udpwr_pkg.sv =====
`default_nettype none

package udpwr_pkg;

  localparam int RECORD_LENGTH = 36;
  localparam int RECORD_BITS   = RECORD_LENGTH * 8;
  localparam int WORD_BITS     = 32;
  localparam int WRENCH_WORDS  = 6;
  localparam int WRENCH_BASE   = 3;
  localparam int POS_W         = $clog2(RECORD_LENGTH + 2);

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(RECORD_LENGTH - 1);
  localparam logic [POS_W-1:0] SAT_POS  = POS_W'(RECORD_LENGTH + 1);
  localparam logic [POS_W-1:0] FULL_POS = POS_W'(RECORD_LENGTH);

  typedef enum logic [1:0] {
    OUTCOME_ACCEPTED   = 2'd0,
    OUTCOME_BAD_LENGTH = 2'd1,
    OUTCOME_REORDERED  = 2'd2
  } outcome_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_datagram;
  } in_item_t;

  typedef struct packed {
    outcome_t           outcome;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic signed [31:0] torque_x;
    logic signed [31:0] torque_y;
    logic signed [31:0] torque_z;
    logic [31:0]        sensor_sample_number;
    logic [31:0]        good_records;
    logic [31:0]        lost_records;
    logic [31:0]        reordered_records;
    logic [31:0]        device_status;
  } out_item_t;

  // One classified datagram: full is set only for a datagram of the record length.
  typedef struct packed {
    logic                   full;
    logic [RECORD_BITS-1:0] bytes;
  } record_t;

  function automatic logic [WORD_BITS-1:0] record_word(input logic [RECORD_BITS-1:0] bytes,
                                                      input int index);
    record_word = bytes[RECORD_BITS-1-WORD_BITS*index -: WORD_BITS];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/udpwr_front.sv =====
`default_nettype none

module udpwr_front
  import udpwr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     item_valid,
  output logic          item_ready,
  input  wire in_item_t item,
  output logic          push_valid,
  input  wire logic     push_ready,
  output record_t       push_data
);

  localparam int SHIFT_BITS = RECORD_BITS - 8;

  logic [POS_W-1:0]      pos;
  logic [SHIFT_BITS-1:0] shift_line;
  logic                  accept;

  assign item_ready = push_ready;
  assign accept     = item_valid && item_ready;
  assign push_valid = item_valid && item.end_of_datagram;

  assign push_data.full  = (pos == LAST_POS);
  assign push_data.bytes = {shift_line, item.data_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (accept) begin
      if (item.end_of_datagram) begin
        pos <= '0;
      end else if (pos != SAT_POS) begin
        pos <= pos + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (pos < FULL_POS)) begin
      shift_line <= {shift_line[SHIFT_BITS-9:0], item.data_byte};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/udpwr_queue.sv =====
`default_nettype none

module udpwr_queue
  import udpwr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push_valid,
  output logic         push_ready,
  input  wire record_t push_data,
  output logic         pop_valid,
  input  wire logic    pop_ready,
  output record_t      pop_data
);

  record_t    entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/udpwr_back.sv =====
`default_nettype none

module udpwr_back
  import udpwr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    pop_valid,
  output logic         pop_ready,
  input  wire record_t pop_data,
  output logic         result_valid,
  input  wire logic    result_ready,
  output out_item_t    result
);

  logic [31:0]                   prev_seq;
  logic [WRENCH_WORDS-1:0][31:0] wrench;
  logic [31:0]                   sample;
  logic [31:0]                   good;
  logic [31:0]                   lost;
  logic [31:0]                   reorder;
  logic [31:0]                   status;

  logic [31:0]                   prev_seq_next;
  logic [WRENCH_WORDS-1:0][31:0] wrench_next;
  logic [31:0]                   sample_next;
  logic [31:0]                   good_next;
  logic [31:0]                   lost_next;
  logic [31:0]                   reorder_next;
  logic [31:0]                   status_next;
  outcome_t                      outcome_next;

  logic [31:0] seq_word;
  logic [31:0] sample_word;
  logic [31:0] status_word;
  logic [31:0] diff;
  logic        out_of_order;
  logic        take;

  assign pop_ready = !result_valid || result_ready;
  assign take      = pop_valid && pop_ready;

  assign seq_word     = record_word(pop_data.bytes, 0);
  assign sample_word  = record_word(pop_data.bytes, 1);
  assign status_word  = record_word(pop_data.bytes, 2);
  assign diff         = seq_word - prev_seq;
  assign out_of_order = (diff == 32'd0) || diff[31];

  always_comb begin
    prev_seq_next = prev_seq;
    wrench_next   = wrench;
    sample_next   = sample;
    good_next     = good;
    lost_next     = lost;
    reorder_next  = reorder;
    status_next   = status;
    outcome_next  = OUTCOME_BAD_LENGTH;
    if (pop_data.full) begin
      prev_seq_next = seq_word;
      if (status_word != 32'd0) begin
        status_next = status_word;
      end
      if (out_of_order) begin
        reorder_next = reorder + 32'd1;
        outcome_next = OUTCOME_REORDERED;
      end else begin
        for (int k = 0; k < WRENCH_WORDS; k++) begin
          wrench_next[k] = record_word(pop_data.bytes, WRENCH_BASE + k);
        end
        sample_next  = sample_word;
        lost_next    = lost + diff - 32'd1;
        good_next    = good + 32'd1;
        outcome_next = OUTCOME_ACCEPTED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_seq     <= '0;
      wrench       <= '0;
      sample       <= '0;
      good         <= '0;
      lost         <= '0;
      reorder      <= '0;
      status       <= '0;
      result_valid <= 1'b0;
    end else begin
      if (take) begin
        prev_seq <= prev_seq_next;
        wrench   <= wrench_next;
        sample   <= sample_next;
        good     <= good_next;
        lost     <= lost_next;
        reorder  <= reorder_next;
        status   <= status_next;
      end
      if (take) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.outcome              <= outcome_next;
      result.force_x              <= $signed(wrench_next[0]);
      result.force_y              <= $signed(wrench_next[1]);
      result.force_z              <= $signed(wrench_next[2]);
      result.torque_x             <= $signed(wrench_next[3]);
      result.torque_y             <= $signed(wrench_next[4]);
      result.torque_z             <= $signed(wrench_next[5]);
      result.sensor_sample_number <= sample_next;
      result.good_records         <= good_next;
      result.lost_records         <= lost_next;
      result.reordered_records    <= reorder_next;
      result.device_status        <= status_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/udp_wrench_record_receiver_core.sv =====
// Takes one datagram byte per cycle, with no gaps of its own making, while the record queue
// has room. A result passes through the two-entry record queue and then the record update
// stage. The update stage handles one datagram per cycle unless its result is held, so bursts
// of short datagrams keep full rate. Synchronous reset clears the byte position, queue,
// counters and held values to zero.
`default_nettype none

module udp_wrench_record_receiver_core
  import udpwr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     item_valid,
  output logic          item_ready,
  input  wire in_item_t item,
  output logic          result_valid,
  input  wire logic     result_ready,
  output out_item_t     result
);

  logic    push_valid;
  logic    push_ready;
  record_t push_data;
  logic    pop_valid;
  logic    pop_ready;
  record_t pop_data;

  udpwr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  udpwr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  udpwr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_data     (pop_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire

// ===== sim/udpwr_checker.sv =====
`timescale 1ns / 100ps

module udpwr_checker
  import udpwr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  input  logic      item_ready,
  input  in_item_t  item,
  input  logic      result_valid,
  input  logic      result_ready,
  input  out_item_t result,
  output int        faults,
  output int        waiting,
  output int        n_accepted,
  output int        n_bad_length,
  output int        n_reordered
);

  logic [5:0]  byte_pos;
  logic [7:0]  frame_bytes [RECORD_LENGTH];
  logic [31:0] last_seq;
  logic [31:0] wrench_hold [WRENCH_WORDS];
  logic [31:0] sample_hold;
  logic [31:0] good_cnt;
  logic [31:0] lost_cnt;
  logic [31:0] reorder_cnt;
  logic [31:0] status_hold;
  out_item_t   report_queue [$];

  function automatic logic [31:0] word_of(input int offset);
    return {frame_bytes[offset], frame_bytes[offset + 1],
            frame_bytes[offset + 2], frame_bytes[offset + 3]};
  endfunction

  task automatic clear_state;
    byte_pos = '0;
    last_seq = '0;
    sample_hold = '0;
    good_cnt = '0;
    lost_cnt = '0;
    reorder_cnt = '0;
    status_hold = '0;
    for (int k = 0; k < WRENCH_WORDS; k++) wrench_hold[k] = '0;
    report_queue.delete();
  endtask

  // Only a datagram of exactly the record length reaches the sequence logic.
  task automatic absorb_byte(input in_item_t it);
    out_item_t   rep;
    logic [31:0] seq;
    logic [31:0] status;
    logic [31:0] diff;
    if (byte_pos < RECORD_LENGTH) frame_bytes[byte_pos] = it.data_byte;
    if (byte_pos < RECORD_LENGTH + 1) byte_pos = byte_pos + 1'b1;
    if (it.end_of_datagram) begin
      rep.outcome = OUTCOME_BAD_LENGTH;
      if (byte_pos == RECORD_LENGTH) begin
        seq = word_of(0);
        status = word_of(8);
        diff = seq - last_seq;
        if (status != 0) status_hold = status;
        last_seq = seq;
        if (diff == 0 || diff[31]) begin
          reorder_cnt = reorder_cnt + 1;
          rep.outcome = OUTCOME_REORDERED;
        end else begin
          for (int k = 0; k < WRENCH_WORDS; k++) wrench_hold[k] = word_of(4 * (WRENCH_BASE + k));
          sample_hold = word_of(4);
          lost_cnt = lost_cnt + diff - 1;
          good_cnt = good_cnt + 1;
          rep.outcome = OUTCOME_ACCEPTED;
        end
      end
      byte_pos = '0;
      case (rep.outcome)
        OUTCOME_ACCEPTED:  n_accepted++;
        OUTCOME_REORDERED: n_reordered++;
        default:           n_bad_length++;
      endcase
      rep.force_x = wrench_hold[0];
      rep.force_y = wrench_hold[1];
      rep.force_z = wrench_hold[2];
      rep.torque_x = wrench_hold[3];
      rep.torque_y = wrench_hold[4];
      rep.torque_z = wrench_hold[5];
      rep.sensor_sample_number = sample_hold;
      rep.good_records = good_cnt;
      rep.lost_records = lost_cnt;
      rep.reordered_records = reorder_cnt;
      rep.device_status = status_hold;
      report_queue.push_back(rep);
    end
  endtask

  task automatic check_word(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      faults++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Each result transaction is matched against the oldest expectation.
  task automatic compare_report(input out_item_t got);
    out_item_t want;
    if (report_queue.size() == 0) begin
      faults++;
      $display("%0t: unexpected result, expected none, actual outcome %0d", $time, got.outcome);
      return;
    end
    want = report_queue.pop_front();
    if (got.outcome !== want.outcome) begin
      faults++;
      $display("%0t: outcome mismatch, expected %0d, actual %0d",
               $time, want.outcome, got.outcome);
    end
    check_word("force_x", want.force_x, got.force_x);
    check_word("force_y", want.force_y, got.force_y);
    check_word("force_z", want.force_z, got.force_z);
    check_word("torque_x", want.torque_x, got.torque_x);
    check_word("torque_y", want.torque_y, got.torque_y);
    check_word("torque_z", want.torque_z, got.torque_z);
    check_word("sensor_sample_number", want.sensor_sample_number, got.sensor_sample_number);
    check_word("good_records", want.good_records, got.good_records);
    check_word("lost_records", want.lost_records, got.lost_records);
    check_word("reordered_records", want.reordered_records, got.reordered_records);
    check_word("device_status", want.device_status, got.device_status);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_state();
    end else begin
      if (result_valid && result_ready) compare_report(result);
      if (item_valid && item_ready) absorb_byte(item);
    end
    waiting <= report_queue.size();
  end

endmodule

// ===== sim/tb_udp_wrench_record_receiver_core.sv =====
`timescale 1ns / 100ps

module tb_udp_wrench_record_receiver_core;
  import udpwr_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  in_item_t    item = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  out_item_t   result;

  int          faults;
  int          waiting;
  int          n_accepted;
  int          n_bad_length;
  int          n_reordered;
  int          send_idle_pct = 13;
  int          recv_idle_pct = 47;
  bit          hold_request = 1'b0;
  int          bytes_sent = 0;
  int          frames_sent = 0;
  int          quiet_cycles = 0;
  logic [7:0]  frame_buf [128];
  logic [31:0] next_seq = '0;

  udp_wrench_record_receiver_core dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  udpwr_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .faults       (faults),
    .waiting      (waiting),
    .n_accepted   (n_accepted),
    .n_bad_length (n_bad_length),
    .n_reordered  (n_reordered)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // The long hold-off lets the block fill up while the sender keeps offering bytes.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        result_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= '{data_byte: b, end_of_datagram: last};
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame(input int len);
    for (int k = 0; k < len; k++) push_byte(frame_buf[k], k == len - 1);
    frames_sent++;
  endtask

  task automatic load_word(input int index, input logic [31:0] value);
    for (int k = 0; k < 4; k++) frame_buf[4 * index + k] = value[31 - 8 * k -: 8];
  endtask

  task automatic send_record(input logic [31:0] seq, input logic [31:0] sample,
                             input logic [31:0] status, input bit fresh_wrench);
    load_word(0, seq);
    load_word(1, sample);
    load_word(2, status);
    if (fresh_wrench) for (int k = WRENCH_BASE; k < 9; k++) load_word(k, $urandom);
    next_seq = seq;
    send_frame(RECORD_LENGTH);
  endtask

  task automatic send_noise(input int len);
    for (int k = 0; k < len; k++) frame_buf[k] = $urandom_range(255);
    send_frame(len);
  endtask

  task automatic drain;
    item_valid <= 1'b0;
    do @(posedge clk); while (waiting != 0);
  endtask

  // Mostly well-formed records with random content and varied sequence steps.
  task automatic random_datagram;
    int          pick;
    int          len;
    logic [31:0] delta;
    pick = $urandom_range(99);
    if (pick < 78) begin
      pick = $urandom_range(99);
      if (pick < 60) delta = 32'd1;
      else if (pick < 80) delta = $urandom_range(6, 2);
      else if (pick < 90) delta = 32'd0 - $urandom_range(4);
      else if (pick < 95) delta = $urandom;
      else delta = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      send_record(next_seq + delta, $urandom,
                  ($urandom_range(3) == 0) ? $urandom : 32'd0, 1'b1);
    end else begin
      len = $urandom_range(40, 1);
      if (len == RECORD_LENGTH) len = RECORD_LENGTH + 1;
      if ($urandom_range(9) == 0) len = $urandom_range(90, 41);
      send_noise(len);
    end
  endtask

  initial begin
    int first_bytes;
    int first_frames;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    frame_buf[0] = 8'hFF;
    send_frame(1);
    load_word(3, 32'h8000_0000);
    load_word(4, 32'h7FFF_FFFF);
    load_word(5, 32'hFFFF_FFFF);
    load_word(6, 32'h0000_0000);
    load_word(7, 32'h0000_0001);
    load_word(8, 32'h5555_5555);
    send_record(32'd1, 32'hFFFF_FFFF, 32'd0, 1'b0);
    send_record(32'd1, 32'd0, 32'hFFFF_FFFF, 1'b1);
    send_record(32'd0, 32'd5, 32'd0, 1'b1);
    send_record(32'h8000_0000, 32'd6, 32'd0, 1'b1);
    send_record(32'hFFFF_FFFF, 32'd7, 32'd1, 1'b1);
    send_record(32'h0000_0002, 32'd8, 32'd0, 1'b1);
    send_record(32'h8000_0001, 32'd9, 32'd0, 1'b1);
    send_record(32'h8000_0004, 32'd10, 32'd0, 1'b1);
    send_noise(RECORD_LENGTH - 1);
    send_noise(RECORD_LENGTH + 1);
    send_noise(RECORD_LENGTH + 2);
    send_noise(100);
    for (int k = 0; k < RECORD_LENGTH; k++) frame_buf[k] = 8'h00;
    send_frame(RECORD_LENGTH);
    for (int k = 0; k < RECORD_LENGTH; k++) frame_buf[k] = 8'hFF;
    send_frame(RECORD_LENGTH);
    next_seq = 32'hFFFF_FFFF;
    send_record(next_seq + 1, 32'd11, 32'd0, 1'b1);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 47 : 0;
      recv_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 13 : 0;
      first_bytes = bytes_sent;
      first_frames = frames_sent;
      if (phase == 0) hold_request = 1'b1;
      while (bytes_sent - first_bytes < 100 ||
             (phase == 0 && frames_sent - first_frames < 4)) begin
        random_datagram();
      end
      drain();
    end

    repeat (8) @(posedge clk);
    $display("Sent %0d bytes in %0d datagrams: %0d accepted, %0d wrong length, %0d reordered.",
             bytes_sent, frames_sent, n_accepted, n_bad_length, n_reordered);
    $display("Both stall mixes, a long result hold-off and full drains were exercised.");
    if (faults == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/udpwr_pkg.sv
rtl/core/udpwr_front.sv
rtl/core/udpwr_queue.sv
rtl/core/udpwr_back.sv
rtl/core/udp_wrench_record_receiver_core.sv
sim/udpwr_checker.sv
sim/tb_udp_wrench_record_receiver_core.sv
